// File: rtl/c_token_classifier_top_assert.svh
// ----------------------------------------------------------------------------
// c_token_classifier_top_assert.svh
// Assertion macros shared by the token classifier modules.
// ----------------------------------------------------------------------------
`ifndef C_TOKEN_CLASSIFIER_TOP_ASSERT_SVH
`define C_TOKEN_CLASSIFIER_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Condition holds at every clock edge out of reset.
`define CTOK_ASSERT(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (cond)) \
    else $error("ctok assertion failed");
// Antecedent implies consequent in the same cycle.
`define CTOK_ASSERT_IMP(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("ctok implication failed");
// Antecedent implies consequent in the next cycle.
`define CTOK_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("ctok next-cycle implication failed");
`else
`define CTOK_ASSERT(lbl, ck, rn, cond)
`define CTOK_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define CTOK_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif

`endif

// File: rtl/ctok_pkg.sv
// ----------------------------------------------------------------------------
// ctok_pkg
// Types, constants and character-class helpers of the token classifier.
// ----------------------------------------------------------------------------
package ctok_pkg;

  localparam int unsigned      DEF_MAX_TOKEN_LENGTH = 255;
  localparam longint unsigned  DEF_POSITION_LIMIT   = 64'd65535;

  localparam int KW_NUM     = 12;
  localparam int KW_SLOTS   = 8;   // padded to a power of two for indexing
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    KIND_KEYWORD    = 3'd0,
    KIND_REAL       = 3'd1,
    KIND_CONSTANT   = 3'd2,
    KIND_IDENTIFIER = 3'd3,
    KIND_UNKNOWN    = 3'd4,
    KIND_DELIMITER  = 3'd5,
    KIND_OPERATOR   = 3'd6
  } ctok_kind_t;

  localparam logic [7:0] KW_TEXT [KW_NUM][KW_SLOTS] = '{
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"f", "l", "o", "a", "t", 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"d", "o", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"f", "o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"b", "r", "e", "a", "k", 8'h00, 8'h00, 8'h00},
    '{"c", "h", "a", "r", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"d", "o", "u", "b", "l", "e", 8'h00, 8'h00}
  };

  localparam logic [2:0] KW_LEN [KW_NUM] = '{
    3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd2, 3'd6, 3'd3, 3'd4, 3'd5, 3'd4, 3'd6
  };

  // One queue entry: the word result and/or the symbol result of one byte.
  typedef struct packed {
    logic       word_v;
    ctok_kind_t word_kind;
    logic [15:0] word_start;
    logic [7:0]  word_len;
    logic        word_sat;
    logic        sym_v;
    ctok_kind_t  sym_kind;
    logic [15:0] sym_pos;
    logic [7:0]  sym_byte;
  } ctok_entry_t;

  // One result item as it leaves the block.
  typedef struct packed {
    ctok_kind_t  kind;
    logic [15:0] start;
    logic [7:0]  len;
    logic [7:0]  sym;
    logic        sat;
    logic        last;
  } ctok_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_delim(input logic [7:0] c);
    return (c == ",") || (c == ";") || (c == "(") || (c == ")") ||
           (c == "{") || (c == "}") || (c == "[") || (c == "]");
  endfunction

  function automatic logic is_oper(input logic [7:0] c);
    return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
           (c == "%") || (c == "=");
  endfunction

endpackage

// File: rtl/ctok_front.sv
// ----------------------------------------------------------------------------
// ctok_front
// Byte front end: tracks the pending token flags and builds queue entries.
// ----------------------------------------------------------------------------
`include "c_token_classifier_top_assert.svh"

module ctok_front #(
  parameter int unsigned     MAX_TOKEN_LENGTH = ctok_pkg::DEF_MAX_TOKEN_LENGTH,
  parameter longint unsigned POSITION_LIMIT   = ctok_pkg::DEF_POSITION_LIMIT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 accept_i,
  input  logic [7:0]           char_i,
  input  logic                 eol_i,
  output logic                 push_o,
  output ctok_pkg::ctok_entry_t entry_o
);
  import ctok_pkg::*;

  localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);
  localparam int POS_W = $clog2(POSITION_LIMIT + 64'd1);

  logic [KW_NUM-1:0] kw_alive_r, kw_alive_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic              first_dig_r, first_dig_nxt;
  logic              ident_ok_r, ident_ok_nxt;
  logic              num_ok_r, num_ok_nxt;
  logic              seen_dot_r, seen_dot_nxt;
  logic              ovf_r, ovf_nxt;
  logic [POS_W-1:0]  start_r, start_nxt;
  logic [POS_W-1:0]  pos_r, pos_nxt;

  // state after appending the current byte
  logic [KW_NUM-1:0] ap_alive;
  logic [LEN_W-1:0]  ap_len;
  logic              ap_first, ap_ident, ap_num, ap_dot, ap_ovf;
  logic [POS_W-1:0]  ap_start;

  // state of the token being flushed
  logic [KW_NUM-1:0] src_alive;
  logic [LEN_W-1:0]  src_len;
  logic              src_first, src_ident, src_num, src_dot, src_ovf;
  logic [POS_W-1:0]  src_start;

  logic       closing, symbol, word_v, kw_hit;
  ctok_kind_t word_kind;

  always_comb begin
    symbol  = is_delim(char_i) || is_oper(char_i);
    closing = symbol || is_space(char_i);

    for (int k = 0; k < KW_NUM; k++) begin
      ap_alive[k] = kw_alive_r[k] && (len_r < LEN_W'(KW_LEN[k])) &&
                    (KW_TEXT[k][len_r[2:0]] == char_i);
    end
    if (len_r == '0) begin
      ap_start = pos_r;
      ap_first = is_digit(char_i);
      ap_ident = is_alpha(char_i) || (char_i == "_");
    end else begin
      ap_start = start_r;
      ap_first = first_dig_r;
      ap_ident = ident_ok_r &&
                 (is_alpha(char_i) || is_digit(char_i) || (char_i == "_"));
    end
    if (char_i == ".") begin
      ap_num = num_ok_r && !seen_dot_r;
      ap_dot = 1'b1;
    end else begin
      ap_num = num_ok_r && is_digit(char_i);
      ap_dot = seen_dot_r;
    end
    if (len_r < LEN_W'(MAX_TOKEN_LENGTH)) begin
      ap_len = len_r + LEN_W'(1);
      ap_ovf = ovf_r;
    end else begin
      ap_len = len_r;
      ap_ovf = 1'b1;
    end

    // a closing byte flushes the token as it stood; end of line after
    // an ordinary byte flushes the token including that byte
    if (closing) begin
      src_alive = kw_alive_r;
      src_len   = len_r;
      src_first = first_dig_r;
      src_ident = ident_ok_r;
      src_num   = num_ok_r;
      src_dot   = seen_dot_r;
      src_ovf   = ovf_r;
      src_start = start_r;
    end else begin
      src_alive = ap_alive;
      src_len   = ap_len;
      src_first = ap_first;
      src_ident = ap_ident;
      src_num   = ap_num;
      src_dot   = ap_dot;
      src_ovf   = ap_ovf;
      src_start = ap_start;
    end

    kw_hit = 1'b0;
    for (int k = 0; k < KW_NUM; k++) begin
      if (src_alive[k] && (src_len == LEN_W'(KW_LEN[k]))) kw_hit = 1'b1;
    end
    kw_hit = kw_hit && !src_ovf;

    priority if (kw_hit)              word_kind = KIND_KEYWORD;
    else if (src_num && src_dot)      word_kind = KIND_REAL;
    else if (src_first)               word_kind = KIND_CONSTANT;
    else if (src_ident)               word_kind = KIND_IDENTIFIER;
    else                              word_kind = KIND_UNKNOWN;

    word_v = (closing || eol_i) && (src_len != '0);

    entry_o.word_v     = word_v;
    entry_o.word_kind  = word_kind;
    entry_o.word_start = 16'(src_start);
    entry_o.word_len   = 8'(src_len);
    entry_o.word_sat   = src_ovf;
    entry_o.sym_v      = symbol;
    entry_o.sym_kind   = is_delim(char_i) ? KIND_DELIMITER : KIND_OPERATOR;
    entry_o.sym_pos    = 16'(pos_r);
    entry_o.sym_byte   = char_i;

    push_o = accept_i && (word_v || symbol);

    // next state: hold without an accepted byte, clear on any flush, else append
    kw_alive_nxt  = kw_alive_r;
    len_nxt       = len_r;
    first_dig_nxt = first_dig_r;
    ident_ok_nxt  = ident_ok_r;
    num_ok_nxt    = num_ok_r;
    seen_dot_nxt  = seen_dot_r;
    ovf_nxt       = ovf_r;
    start_nxt     = start_r;
    pos_nxt       = pos_r;
    if (accept_i) begin
      pos_nxt = (pos_r == POS_W'(POSITION_LIMIT)) ? '0 : pos_r + POS_W'(1);
      if (closing || eol_i) begin
        kw_alive_nxt  = '1;
        len_nxt       = '0;
        first_dig_nxt = 1'b0;
        ident_ok_nxt  = 1'b1;
        num_ok_nxt    = 1'b1;
        seen_dot_nxt  = 1'b0;
        ovf_nxt       = 1'b0;
        start_nxt     = '0;
      end else begin
        kw_alive_nxt  = ap_alive;
        len_nxt       = ap_len;
        first_dig_nxt = ap_first;
        ident_ok_nxt  = ap_ident;
        num_ok_nxt    = ap_num;
        seen_dot_nxt  = ap_dot;
        ovf_nxt       = ap_ovf;
        start_nxt     = ap_start;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_alive_r  <= '1;
      len_r       <= '0;
      first_dig_r <= 1'b0;
      ident_ok_r  <= 1'b1;
      num_ok_r    <= 1'b1;
      seen_dot_r  <= 1'b0;
      ovf_r       <= 1'b0;
      start_r     <= '0;
      pos_r       <= '0;
    end else begin
      kw_alive_r  <= kw_alive_nxt;
      len_r       <= len_nxt;
      first_dig_r <= first_dig_nxt;
      ident_ok_r  <= ident_ok_nxt;
      num_ok_r    <= num_ok_nxt;
      seen_dot_r  <= seen_dot_nxt;
      ovf_r       <= ovf_nxt;
      start_r     <= start_nxt;
      pos_r       <= pos_nxt;
    end
  end

  `CTOK_ASSERT_NEXT(a_eol_clears, clk, rst_n, accept_i && eol_i, len_r == '0)
  `CTOK_ASSERT_IMP(a_sat_full, clk, rst_n, ovf_r, len_r == LEN_W'(MAX_TOKEN_LENGTH))

endmodule

// File: rtl/ctok_queue.sv
// ----------------------------------------------------------------------------
// ctok_queue
// Short FIFO of entries between the front end and the result sequencer.
// ----------------------------------------------------------------------------
`include "c_token_classifier_top_assert.svh"

module ctok_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push_i,
  input  ctok_pkg::ctok_entry_t entry_i,
  output logic                  full_o,
  input  logic                  pop_i,
  output logic                  avail_o,
  output ctok_pkg::ctok_entry_t head_o
);
  import ctok_pkg::*;

  ctok_entry_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   count_r, count_nxt;
  logic              do_push, do_pop;

  always_comb begin
    full_o  = (count_r == (QPTR_W + 1)'(QUEUE_DEPTH));
    avail_o = (count_r != '0);
    head_o  = mem[rd_ptr_r];
    do_push = push_i && !full_o;
    do_pop  = pop_i && avail_o;
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) count_nxt = count_r + (QPTR_W + 1)'(1);
    if (do_pop && !do_push) count_nxt = count_r - (QPTR_W + 1)'(1);
  end

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr_r] <= entry_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  `CTOK_ASSERT_IMP(a_no_overflow, clk, rst_n, push_i, !full_o)
  `CTOK_ASSERT(a_count_range, clk, rst_n, count_r <= (QPTR_W + 1)'(QUEUE_DEPTH))

endmodule

// File: rtl/ctok_back.sv
// ----------------------------------------------------------------------------
// ctok_back
// Result sequencer: splits each entry into results and drives the output.
// ----------------------------------------------------------------------------
`include "c_token_classifier_top_assert.svh"

module ctok_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  avail_i,
  input  ctok_pkg::ctok_entry_t head_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ctok_pkg::ctok_result_t out_res_o
);
  import ctok_pkg::*;

  ctok_entry_t  cur_r, cur_nxt;
  logic         cur_valid_r, cur_valid_nxt;
  logic         out_valid_r, out_valid_nxt;
  ctok_result_t out_res_r, out_res_nxt;
  logic         can_load, emit, cur_done;

  always_comb begin
    can_load = !out_valid_r || out_ready_i;
    emit     = can_load && cur_valid_r;

    // word result goes first; symbol result follows
    if (cur_r.word_v) begin
      out_res_nxt.kind  = cur_r.word_kind;
      out_res_nxt.start = cur_r.word_start;
      out_res_nxt.len   = cur_r.word_len;
      out_res_nxt.sym   = 8'h00;
      out_res_nxt.sat   = cur_r.word_sat;
      out_res_nxt.last  = !cur_r.sym_v;
      cur_done          = !cur_r.sym_v;
    end else begin
      out_res_nxt.kind  = cur_r.sym_kind;
      out_res_nxt.start = cur_r.sym_pos;
      out_res_nxt.len   = 8'd1;
      out_res_nxt.sym   = cur_r.sym_byte;
      out_res_nxt.sat   = 1'b0;
      out_res_nxt.last  = 1'b1;
      cur_done          = 1'b1;
    end

    out_valid_nxt = can_load ? emit : out_valid_r;

    pop_o = avail_i && (!cur_valid_r || (emit && cur_done));

    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    if (pop_o) begin
      cur_nxt       = head_i;
      cur_valid_nxt = 1'b1;
    end else if (emit) begin
      if (cur_done) cur_valid_nxt = 1'b0;
      else          cur_nxt.word_v = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    if (emit) out_res_r <= out_res_nxt;
  end

  assign out_valid_o = out_valid_r;
  assign out_res_o   = out_res_r;

  `CTOK_ASSERT_IMP(a_entry_nonempty, clk, rst_n, cur_valid_r, cur_r.word_v || cur_r.sym_v)
  `CTOK_ASSERT_NEXT(a_symbol_kept, clk, rst_n, emit && !cur_done,
                    cur_valid_r && cur_r.sym_v && !cur_r.word_v)

endmodule

// File: rtl/c_token_classifier_top.sv
// A result passes the queue, the current-entry register and the output register.
// Throughput: one byte per cycle while the queue has room; the output port emits
// one result per cycle while out_tready is high, so a byte that closes a token
// with a delimiter or operator yields two results. A 4-entry queue absorbs that.
// Reset (rst_n low, synchronous): no token pending, stream position zero,
// queue and output register empty; the block accepts bytes the cycle after.
// ----------------------------------------------------------------------------
// c_token_classifier_top
// Byte-serial lexical analyzer for C-like text: classifies word tokens
// incrementally and reports delimiters and operators as their own results.
// ----------------------------------------------------------------------------
module c_token_classifier_top #(
  parameter int unsigned     MAX_TOKEN_LENGTH = ctok_pkg::DEF_MAX_TOKEN_LENGTH,
  parameter longint unsigned POSITION_LIMIT   = ctok_pkg::DEF_POSITION_LIMIT
) (
  input  logic        clk,
  input  logic        rst_n,
  // input stream: one source byte per transaction
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tlast,   // end_of_line
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [15:0] start_position, [23:16] token_length,
                                  // [31:24] symbol_byte, [32] length_saturated,
                                  // [39:33] zero
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast   // last_result
);
  import ctok_pkg::*;

  logic         accept;
  logic         push;
  ctok_entry_t  entry;
  logic         q_full;
  logic         pop;
  logic         q_avail;
  ctok_entry_t  head;
  ctok_result_t res;

  // Take a byte whenever the queue has a free slot; the front end is
  // a plain registered flag update, so nothing else holds the input back.
  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Front end: update the pending token flags, build the entry holding the
  // flushed word result and/or the symbol result of this byte.
  ctok_front #(
    .MAX_TOKEN_LENGTH (MAX_TOKEN_LENGTH),
    .POSITION_LIMIT   (POSITION_LIMIT)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .char_i   (in_tdata),
    .eol_i    (in_tlast),
    .push_o   (push),
    .entry_o  (entry)
  );

  // Queue: decouple byte intake from result delivery.
  ctok_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .entry_i (entry),
    .full_o  (q_full),
    .pop_i   (pop),
    .avail_o (q_avail),
    .head_o  (head)
  );

  // Back end: split entries into results, hold each in the output register
  // until the downstream side takes it.
  ctok_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .avail_i     (q_avail),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_res_o   (res)
  );

  // Pack the result payload; pad upper bits with zeros.
  assign out_tdata = {7'd0, res.sat, res.sym, res.len, res.start};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule
